FILE: design/entropy_pool_scheduler_assert.svh
// assertion macros used by the top-level design file
`ifndef ENTROPY_POOL_SCHEDULER_ASSERT_SVH
`define ENTROPY_POOL_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define EPSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("entropy_pool_scheduler: check failed");

// next-cycle implication
`define EPSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("entropy_pool_scheduler: check failed");

`endif

FILE: design/epsc_pkg.sv
package epsc_pkg;

   localparam int NUM_SOURCES = 16;
   localparam int DERIV_ORDER = 16;
   localparam int NUM_POOLS   = 32;

   localparam int SRC_AW  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int STEP_AW = (DERIV_ORDER > 1) ? $clog2(DERIV_ORDER) : 1;
   localparam int HIST_AW = SRC_AW + STEP_AW;

   localparam int SAMPLE_W   = 32;
   localparam int COUNT_W    = 32;
   localparam int ROUND_W    = 32;
   localparam int POOL_W     = 5;
   localparam int MASK_W     = 32;
   localparam int BYTES_W    = 16;
   localparam int THRESH_W   = 16;
   localparam int MINDIFF_W  = 8;
   localparam int SRCID_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [THRESH_W-1:0]  RESEED_THRESHOLD_RST = 16'd256;
   localparam logic [MINDIFF_W-1:0] MIN_DIFFERENCE_RST   = 8'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RESEED_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIFFERENCE   = 1'b1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_BYTES  = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [SRCID_W-1:0]  source_id;
      logic [SAMPLE_W-1:0] sample_value;
      logic [BYTES_W-1:0]  byte_count;
      logic                batch_end;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [POOL_W-1:0]  pool_index;
      logic               reseed_now;
      logic [MASK_W-1:0]  pool_mask;
      logic               include_old_key;
      logic [ROUND_W-1:0] round_number;
   } rsp_type;

   // control from the sequencer to the accounting unit
   typedef struct packed {
      logic               upd;
      logic               check;
      logic               is_bytes;
      logic               pass;
      logic [SRC_AW-1:0]  src;
      logic [BYTES_W-1:0] byte_count;
      logic               batch_end;
   } acct_ctl_type;

endpackage

FILE: design/epsc_hist_ram.sv
module epsc_hist_ram #(
   parameter int AW = 8,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/epsc_chain.sv
module epsc_chain (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [epsc_pkg::SRC_AW-1:0]    src,
   input  logic [epsc_pkg::SAMPLE_W-1:0]  sample,
   input  logic [epsc_pkg::MINDIFF_W-1:0] min_diff,
   output logic                           done,
   output logic                           pass
);

   localparam logic [epsc_pkg::STEP_AW-1:0] LAST_STEP =
      epsc_pkg::STEP_AW'(epsc_pkg::DERIV_ORDER - 1);

   logic                            busy_ff;
   logic                            fin_ff;
   logic                            first_ff;
   logic                            rej_ff;
   logic [epsc_pkg::STEP_AW-1:0]    step_ff;
   logic [epsc_pkg::SRC_AW-1:0]     src_ff;
   logic [epsc_pkg::SAMPLE_W-1:0]   v_ff;
   logic [epsc_pkg::NUM_SOURCES-1:0] row_valid_ff;

   logic                            rd_en;
   logic [epsc_pkg::HIST_AW-1:0]    rd_addr;
   logic [epsc_pkg::SAMPLE_W-1:0]   rd_data;
   logic [epsc_pkg::SAMPLE_W-1:0]   prev;
   logic [epsc_pkg::SAMPLE_W-1:0]   diff;
   logic                            low;

   // a row never written reads as zero
   assign prev = row_valid_ff[src_ff] ? rd_data : '0;
   assign diff = (v_ff >= prev) ? (v_ff - prev) : (prev - v_ff);
   assign low  = v_ff < epsc_pkg::SAMPLE_W'(min_diff);

   assign rd_en   = start | (busy_ff & (step_ff != LAST_STEP));
   assign rd_addr = start ? {src, epsc_pkg::STEP_AW'(0)}
                          : {src_ff, epsc_pkg::STEP_AW'(step_ff + 1'b1)};

   epsc_hist_ram #(
      .AW(epsc_pkg::HIST_AW),
      .DW(epsc_pkg::SAMPLE_W)
   ) u_hist_ram (
      .clock  (clock),
      .wr_en  (busy_ff),
      .wr_addr({src_ff, step_ff}),
      .wr_data(v_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         fin_ff <= !start && busy_ff && (step_ff == LAST_STEP);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
         end
         if (fin_ff) begin
            row_valid_ff[src_ff] <= 1'b1;
         end
      end
   end

   // walk the row one difference per cycle, writing back the value seen
   always_ff @(posedge clock) begin
      if (start) begin
         src_ff   <= src;
         v_ff     <= sample;
         step_ff  <= '0;
         first_ff <= 1'b1;
         rej_ff   <= 1'b0;
      end else if (busy_ff) begin
         v_ff     <= diff;
         first_ff <= 1'b0;
         step_ff  <= epsc_pkg::STEP_AW'(step_ff + 1'b1);
         if (!first_ff && low) begin
            rej_ff <= 1'b1;
         end
      end
   end

   // last difference is checked on the finishing cycle
   assign done = fin_ff;
   assign pass = !(rej_ff | low);

endmodule

FILE: design/epsc_acct.sv
module epsc_acct (
   input  logic                          clock,
   input  logic                          reset,
   input  epsc_pkg::acct_ctl_type        ctl,
   input  logic [epsc_pkg::THRESH_W-1:0] threshold,
   output epsc_pkg::rsp_type             rsp
);

   function automatic logic [epsc_pkg::MASK_W-1:0] drain_mask(
      input logic [epsc_pkg::ROUND_W-1:0] rounds
   );
      logic [epsc_pkg::MASK_W-1:0]  mask;
      logic [epsc_pkg::ROUND_W-1:0] below;
      for (int i = 0; i < epsc_pkg::MASK_W; i++) begin
         below   = (epsc_pkg::ROUND_W'(1) << i) - epsc_pkg::ROUND_W'(1);
         mask[i] = (i < epsc_pkg::NUM_POOLS) && ((rounds & below) == '0);
      end
      return mask;
   endfunction

   logic [epsc_pkg::COUNT_W-1:0] count_ff;
   logic [epsc_pkg::ROUND_W-1:0] rounds_ff;
   logic                         seeded_ff;
   logic [epsc_pkg::POOL_W-1:0]  next_pool_ff [epsc_pkg::NUM_SOURCES];
   logic                         acc_ff;
   logic [epsc_pkg::POOL_W-1:0]  pidx_ff;

   logic [epsc_pkg::POOL_W-1:0]  cur_pool;
   logic [epsc_pkg::POOL_W-1:0]  pool_in;
   logic [epsc_pkg::COUNT_W:0]   add_amt;
   logic [epsc_pkg::COUNT_W:0]   sum;
   logic [epsc_pkg::COUNT_W-1:0] count_in;
   logic                         bump;
   logic                         take;
   logic                         reseed;
   logic [epsc_pkg::ROUND_W-1:0] rounds_in;

   assign cur_pool = next_pool_ff[ctl.src];
   assign pool_in  = (cur_pool == epsc_pkg::POOL_W'(epsc_pkg::NUM_POOLS - 1)) ? '0
                                                                            : cur_pool + 1'b1;
   assign take     = !ctl.is_bytes && ctl.pass;
   assign bump     = ctl.is_bytes || (take && cur_pool == '0);

   // eight counts per external byte, saturating
   assign add_amt  = ctl.is_bytes ? (epsc_pkg::COUNT_W+1)'({ctl.byte_count, 3'b000})
                                  : (epsc_pkg::COUNT_W+1)'(1);
   assign sum      = {1'b0, count_ff} + add_amt;
   assign count_in = sum[epsc_pkg::COUNT_W] ? '1 : sum[epsc_pkg::COUNT_W-1:0];

   assign reseed    = ctl.batch_end && (count_ff >= epsc_pkg::COUNT_W'(threshold));
   assign rounds_in = rounds_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rounds_ff <= '0;
         seeded_ff <= 1'b0;
         for (int i = 0; i < epsc_pkg::NUM_SOURCES; i++) begin
            next_pool_ff[i] <= '0;
         end
      end else begin
         if (ctl.upd) begin
            if (bump) begin
               count_ff <= count_in;
            end
            if (take) begin
               next_pool_ff[ctl.src] <= pool_in;
            end
         end
         if (ctl.check && reseed) begin
            rounds_ff <= rounds_in;
            count_ff  <= '0;
            seeded_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.upd) begin
         acc_ff  <= ctl.is_bytes || ctl.pass;
         pidx_ff <= take ? cur_pool : '0;
      end
   end

   always_comb begin
      rsp.accepted        = acc_ff;
      rsp.pool_index      = pidx_ff;
      rsp.reseed_now      = reseed;
      rsp.pool_mask       = reseed ? drain_mask(rounds_in) : '0;
      rsp.include_old_key = reseed && seeded_ff;
      rsp.round_number    = reseed ? rounds_in : rounds_ff;
   end

endmodule

FILE: design/entropy_pool_scheduler.sv
// Entropy pool scheduler: filters tagged timing samples through a per-source chain of
// absolute differences, spreads accepted samples round robin over the pools, counts
// pool zero entropy and orders reseeds at batch ends. One item is worked on at a time
// and each item gives one result. The difference history of each source
// lives in one memory with one read and one write port, and the row is walked one
// difference per cycle with a read-modify-write of each entry. An external-bytes item
// or a sample from an unknown source skips the chain. The result sits in an output
// register, so the next item is taken while a result waits; that next item then holds
// in its last step until the waiting result is taken. A valid bit per source row
// stands for the cleared history, so no clearing pass runs after reset.
`include "entropy_pool_scheduler_assert.svh"

module entropy_pool_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  epsc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output epsc_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [epsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [epsc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHAIN = 4'b0010,
      ST_ACCT  = 4'b0100,
      ST_CHECK = 4'b1000
   } state_type;

   state_type                        state_ff;
   epsc_pkg::req_type                req_ff;
   logic                             pass_ff;
   logic                             rsp_valid_ff;
   epsc_pkg::rsp_type                rsp_ff;
   logic [epsc_pkg::THRESH_W-1:0]    thresh_ff;
   logic [epsc_pkg::MINDIFF_W-1:0]   min_diff_ff;

   logic                             req_fire;
   logic                             in_range;
   logic                             start_chain;
   logic                             out_free;
   logic                             chain_done;
   logic                             chain_pass;
   epsc_pkg::acct_ctl_type           ctl;
   epsc_pkg::rsp_type                acct_rsp;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign in_range    = int'(req_data.source_id) < epsc_pkg::NUM_SOURCES;
   assign start_chain = req_fire && req_data.cmd == epsc_pkg::CMD_SAMPLE && in_range;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign ctl.upd        = (state_ff == ST_ACCT);
   assign ctl.check      = (state_ff == ST_CHECK) && out_free;
   assign ctl.is_bytes   = (req_ff.cmd == epsc_pkg::CMD_BYTES);
   assign ctl.pass       = pass_ff;
   assign ctl.src        = epsc_pkg::SRC_AW'(req_ff.source_id);
   assign ctl.byte_count = req_ff.byte_count;
   assign ctl.batch_end  = req_ff.batch_end;

   epsc_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .start   (start_chain),
      .src     (epsc_pkg::SRC_AW'(req_data.source_id)),
      .sample  (req_data.sample_value),
      .min_diff(min_diff_ff),
      .done    (chain_done),
      .pass    (chain_pass)
   );

   epsc_acct u_acct (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .threshold(thresh_ff),
      .rsp      (acct_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= epsc_pkg::RESEED_THRESHOLD_RST;
         min_diff_ff  <= epsc_pkg::MIN_DIFFERENCE_RST;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= start_chain ? ST_CHAIN : ST_ACCT;
               end
            end
            ST_CHAIN: begin
               if (chain_done) begin
                  state_ff <= ST_ACCT;
               end
            end
            ST_ACCT: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (ctl.check) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            case (csr_index)
               epsc_pkg::CSR_RESEED_THRESHOLD: thresh_ff <= csr_wdata;
               epsc_pkg::CSR_MIN_DIFFERENCE: begin
                  min_diff_ff <= csr_wdata[epsc_pkg::MINDIFF_W-1:0];
               end
               default: ;
            endcase
         end
      end
   end

   // item and result holding registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff  <= req_data;
         pass_ff <= 1'b0;
      end else if (state_ff == ST_CHAIN && chain_done) begin
         pass_ff <= chain_pass;
      end
      if (ctl.check) begin
         rsp_ff <= acct_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `EPSC_ASSERT_IMPL(a_done_in_chain, clock, reset, chain_done, state_ff == ST_CHAIN)
   `EPSC_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   `EPSC_ASSERT_IMPL(a_quiet_result, clock, reset, rsp_valid && !rsp_data.reseed_now, rsp_data.pool_mask == '0 && !rsp_data.include_old_key)
   `EPSC_ASSERT_IMPL(a_reseed_pool0, clock, reset, rsp_valid && rsp_data.reseed_now, rsp_data.pool_mask[0])

endmodule

FILE: sim/entropy_pool_scheduler_tb.sv
`timescale 1ns / 1ps

module entropy_pool_scheduler_tb;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   epsc_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   epsc_pkg::rsp_type               rsp_data;
   logic                            csr_we = 1'b0;
   logic [epsc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [epsc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   entropy_pool_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // scheduler shadow state
   logic [epsc_pkg::SAMPLE_W-1:0]  diff_hist [epsc_pkg::NUM_SOURCES][epsc_pkg::DERIV_ORDER];
   logic [epsc_pkg::POOL_W-1:0]    pool_ptr [epsc_pkg::NUM_SOURCES];
   logic [epsc_pkg::COUNT_W-1:0]   pool0_credit;
   logic [epsc_pkg::ROUND_W-1:0]   round_tally;
   logic                           seeded;
   logic [epsc_pkg::THRESH_W-1:0]  cfg_threshold;
   logic [epsc_pkg::MINDIFF_W-1:0] cfg_min_diff;

   epsc_pkg::req_type             pending_items[$];
   epsc_pkg::rsp_type             pending_decisions[$];
   logic [epsc_pkg::SAMPLE_W-1:0] last_sample [epsc_pkg::NUM_SOURCES];
   int                            idle_left = 0;
   int                            stall_left = 0;
   int                            fail_count = 0;
   bit                            no_pause = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void add_credit(input logic [epsc_pkg::COUNT_W:0] amount);
      logic [epsc_pkg::COUNT_W:0] sum;
      sum = {1'b0, pool0_credit} + amount;
      pool0_credit = sum[epsc_pkg::COUNT_W] ? '1 : sum[epsc_pkg::COUNT_W-1:0];
   endfunction

   function automatic epsc_pkg::rsp_type schedule_item(input epsc_pkg::req_type item);
      epsc_pkg::rsp_type             res;
      logic [epsc_pkg::SAMPLE_W-1:0] v;
      logic [epsc_pkg::SAMPLE_W-1:0] prev;
      logic [epsc_pkg::SAMPLE_W-1:0] lowest;
      logic [epsc_pkg::POOL_W-1:0]   p;
      logic [epsc_pkg::MASK_W-1:0]   mask;
      logic                          stop;
      res = '0;
      if (item.cmd == epsc_pkg::CMD_BYTES) begin
         add_credit((epsc_pkg::COUNT_W + 1)'(item.byte_count) * 8);
         res.accepted = 1'b1;
      end else if (int'(item.source_id) < epsc_pkg::NUM_SOURCES) begin
         v = item.sample_value;
         lowest = '1;
         // walk the difference chain, history keeps the inputs of each order
         for (int i = 0; i < epsc_pkg::DERIV_ORDER; i++) begin
            prev = diff_hist[item.source_id][i];
            diff_hist[item.source_id][i] = v;
            v = (v >= prev) ? v - prev : prev - v;
            if (v < lowest)
               lowest = v;
         end
         if (lowest >= cfg_min_diff) begin
            p = pool_ptr[item.source_id];
            res.accepted = 1'b1;
            res.pool_index = p;
            if (p == 0)
               add_credit(1);
            pool_ptr[item.source_id] = (p == epsc_pkg::NUM_POOLS - 1) ? '0 : p + 1'b1;
         end
      end
      if (item.batch_end && pool0_credit >= cfg_threshold) begin
         round_tally = round_tally + 1'b1;
         res.reseed_now = 1'b1;
         res.include_old_key = seeded;
         // pools 0..t with t the trailing zeros of the new round count
         mask = 1;
         stop = 1'b0;
         for (int i = 1; i < epsc_pkg::NUM_POOLS; i++) begin
            if (round_tally[i-1])
               stop = 1'b1;
            if (!stop)
               mask[i] = 1'b1;
         end
         res.pool_mask = mask;
         pool0_credit = '0;
         seeded = 1'b1;
      end
      res.round_number = round_tally;
      return res;
   endfunction

   function automatic int draw_pause(input int long_max);
      int roll;
      roll = $urandom_range(99);
      if (no_pause || roll < 55)
         return 0;
      if (roll < 93)
         return $urandom_range(3, 1);
      return $urandom_range(long_max, 8);
   endfunction

   function automatic epsc_pkg::req_type sample_item(
      input logic [epsc_pkg::SRCID_W-1:0]  src,
      input logic [epsc_pkg::SAMPLE_W-1:0] val,
      input logic                          bend
   );
      epsc_pkg::req_type item;
      item.cmd = epsc_pkg::CMD_SAMPLE;
      item.source_id = src;
      item.sample_value = val;
      item.byte_count = epsc_pkg::BYTES_W'($urandom_range(65535));
      item.batch_end = bend;
      return item;
   endfunction

   function automatic epsc_pkg::req_type bytes_item(input logic [epsc_pkg::BYTES_W-1:0] count,
                                                    input logic bend);
      epsc_pkg::req_type item;
      item.cmd = epsc_pkg::CMD_BYTES;
      item.source_id = epsc_pkg::SRCID_W'($urandom_range(epsc_pkg::NUM_SOURCES - 1));
      item.sample_value = $urandom;
      item.byte_count = count;
      item.batch_end = bend;
      return item;
   endfunction

   function automatic epsc_pkg::req_type random_item();
      epsc_pkg::req_type             item;
      int                            pick;
      logic [epsc_pkg::SAMPLE_W-1:0] base;
      item.cmd = ($urandom_range(9) < 3) ? epsc_pkg::CMD_BYTES : epsc_pkg::CMD_SAMPLE;
      item.source_id = epsc_pkg::SRCID_W'($urandom_range(epsc_pkg::NUM_SOURCES - 1));
      item.batch_end = ($urandom_range(5) == 0);
      pick = $urandom_range(99);
      if (pick < 50)
         item.byte_count = epsc_pkg::BYTES_W'($urandom_range(65535));
      else if (pick < 80)
         item.byte_count = epsc_pkg::BYTES_W'($urandom_range(64));
      else if (pick < 90)
         item.byte_count = '0;
      else
         item.byte_count = '1;
      base = last_sample[item.source_id];
      // repeats and small steps trip the filter, wide values pass it
      pick = $urandom_range(99);
      if (pick < 30)
         item.sample_value = $urandom;
      else if (pick < 50)
         item.sample_value = base;
      else if (pick < 65)
         item.sample_value = base + $urandom_range(300);
      else if (pick < 80)
         item.sample_value = base - $urandom_range(300);
      else if (pick < 93)
         item.sample_value = $urandom_range(1000);
      else
         item.sample_value = pick[0] ? '1 : '0;
      if (item.cmd == epsc_pkg::CMD_SAMPLE)
         last_sample[item.source_id] = item.sample_value;
      return item;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && req_ready)
            pending_decisions.push_back(schedule_item(req_data));
         if (!req_valid || req_ready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_items.pop_front();
               idle_left = draw_pause(40);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      epsc_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_decisions.size() == 0) begin
               $error("result transfer with no decision pending");
               fail_count++;
            end else begin
               want = pending_decisions.pop_front();
               check_field("accepted", want.accepted, rsp_data.accepted);
               check_field("pool_index", want.pool_index, rsp_data.pool_index);
               check_field("reseed_now", want.reseed_now, rsp_data.reseed_now);
               check_field("pool_mask", want.pool_mask, rsp_data.pool_mask);
               check_field("include_old_key", want.include_old_key,
                           rsp_data.include_old_key);
               check_field("round_number", want.round_number, rsp_data.round_number);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = ($urandom_range(5) == 0) ? draw_pause(30) : 0;
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   // sampled away from the driving edge so queue and valid agree
   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || pending_decisions.size() != 0)
         @(negedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input logic [epsc_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [epsc_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == epsc_pkg::CSR_RESEED_THRESHOLD)
         cfg_threshold = data[epsc_pkg::THRESH_W-1:0];
      else
         cfg_min_diff = data[epsc_pkg::MINDIFF_W-1:0];
   endtask

   initial begin
      logic [epsc_pkg::THRESH_W-1:0]  th;
      logic [epsc_pkg::MINDIFF_W-1:0] md;
      for (int s = 0; s < epsc_pkg::NUM_SOURCES; s++) begin
         for (int i = 0; i < epsc_pkg::DERIV_ORDER; i++)
            diff_hist[s][i] = '0;
         pool_ptr[s] = '0;
         last_sample[s] = '0;
      end
      pool0_credit = '0;
      round_tally = '0;
      seeded = 1'b0;
      cfg_threshold = epsc_pkg::RESEED_THRESHOLD_RST;
      cfg_min_diff = epsc_pkg::MIN_DIFFERENCE_RST;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register values after reset
      pending_items.push_back(sample_item(4'd0, 32'h0, 1'b0));
      pending_items.push_back(sample_item(4'd0, 32'hFFFF_FFFF, 1'b0));
      pending_items.push_back(sample_item(4'd15, 32'h1, 1'b0));
      pending_items.push_back(sample_item(4'd15, 32'h1, 1'b0));
      pending_items.push_back(sample_item(4'd7, 32'h8000_0000, 1'b1));
      pending_items.push_back(bytes_item(16'd0, 1'b1));
      pending_items.push_back(bytes_item(16'd31, 1'b0));
      pending_items.push_back(bytes_item(16'd1, 1'b1));
      pending_items.push_back(bytes_item(16'hFFFF, 1'b1));
      pending_items.push_back(sample_item(4'd7, 32'h8000_0000, 1'b0));
      pending_items.push_back(sample_item(4'd7, 32'h8000_0002, 1'b0));
      wait_drained();

      // zero threshold reseeds on every batch end, zero min difference passes all
      write_reg(epsc_pkg::CSR_RESEED_THRESHOLD, 16'd0);
      write_reg(epsc_pkg::CSR_MIN_DIFFERENCE, 16'h0000);
      pending_items.push_back(sample_item(4'd3, 32'h3, 1'b1));
      pending_items.push_back(sample_item(4'd3, 32'h3, 1'b1));
      pending_items.push_back(bytes_item(16'd0, 1'b1));
      wait_drained();

      write_reg(epsc_pkg::CSR_RESEED_THRESHOLD, 16'hFFFF);
      write_reg(epsc_pkg::CSR_MIN_DIFFERENCE, 16'hA5FF);
      pending_items.push_back(bytes_item(16'd8191, 1'b0));
      pending_items.push_back(bytes_item(16'd0, 1'b1));
      pending_items.push_back(bytes_item(16'd1, 1'b1));
      pending_items.push_back(sample_item(4'd9, 32'd200, 1'b0));
      pending_items.push_back(sample_item(4'd9, 32'h0000_FFFF, 1'b1));
      wait_drained();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin
               th = 16'd256;
               md = 8'd2;
            end
            1: begin
               th = 16'd1;
               md = 8'd0;
            end
            2: begin
               th = 16'd0;
               md = 8'd255;
            end
            3: begin
               th = 16'hFFFF;
               md = 8'd1;
            end
            4: begin
               th = epsc_pkg::THRESH_W'($urandom_range(64, 2));
               md = epsc_pkg::MINDIFF_W'($urandom_range(255));
            end
            5: begin
               th = 16'd16;
               md = 8'd2;
            end
            6: begin
               th = epsc_pkg::THRESH_W'($urandom_range(65535));
               md = 8'd255;
            end
            7: begin
               th = 16'd1;
               md = 8'd0;
            end
            8: begin
               th = 16'd4096;
               md = epsc_pkg::MINDIFF_W'($urandom_range(16, 1));
            end
            default: begin
               th = 16'hFFFF;
               md = 8'd2;
            end
         endcase
         write_reg(epsc_pkg::CSR_RESEED_THRESHOLD, th);
         write_reg(epsc_pkg::CSR_MIN_DIFFERENCE, {8'($urandom_range(255)), md});
         no_pause = (ph == 3 || ph == 7);
         repeat (155) pending_items.push_back(random_item());
         wait_drained();
      end

      if (fail_count == 0)
         $display("PASS entropy_pool_scheduler");
      else
         $display("FAIL entropy_pool_scheduler");
      $finish;
   end

   initial begin
      #(30_000_000);
      $display("FAIL entropy_pool_scheduler");
      $finish;
   end

endmodule
